// ===== hw/rtl/i2cra_pkg.sv =====
// Shared types and constants for the I2C register access master.
// No dependencies; used by the sequencer and the top level.
package i2cra_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 10;

  localparam logic [CfgIdxW-1:0] CFG_DEVICE_ADDRESS    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_HALF_PERIOD_TICKS = 2'd1;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [6:0] DEV_ADDR_RESET    = 7'h18;
  localparam logic [9:0] HALF_PERIOD_RESET = 10'd10;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] reg_num;
    logic [7:0] write_data;
    logic       sda_in;
  } in_t;

  typedef struct packed {
    logic       scl;
    logic       sda_out;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
  } res_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
  } cfg_wr_t;

  // Register file contents handed to the sequencer
  typedef struct packed {
    logic [6:0] device_address;
    logic [9:0] half_period_ticks;
  } cfg_regs_t;

endpackage

// ===== hw/rtl/i2cra_stream_if.sv =====
// Valid/ready channel carrying one payload per transfer.
// Payload type is supplied per instance, normally from i2cra_pkg.
interface i2cra_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/i2cra_seq.sv =====
// Phase sequencer: holds transaction state and computes line levels per tick.
// Depends on i2cra_pkg for the item, result and register types.
module i2cra_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_en_i,
  input  i2cra_pkg::in_t      item_i,
  input  i2cra_pkg::cfg_regs_t regs_i,
  output i2cra_pkg::res_t     res_o
);

  typedef enum logic [13:0] {
    ST_IDLE    = 14'b00000000000001,
    ST_START_A = 14'b00000000000010,
    ST_START_B = 14'b00000000000100,
    ST_WBIT_LO = 14'b00000000001000,
    ST_WBIT_HI = 14'b00000000010000,
    ST_WACK_LO = 14'b00000000100000,
    ST_WACK_HI = 14'b00000001000000,
    ST_RBIT_LO = 14'b00000010000000,
    ST_RBIT_HI = 14'b00000100000000,
    ST_NACK_LO = 14'b00001000000000,
    ST_NACK_HI = 14'b00010000000000,
    ST_STOP_A  = 14'b00100000000000,
    ST_STOP_B  = 14'b01000000000000,
    ST_STOP_C  = 14'b10000000000000
  } state_e;

  localparam logic [1:0] SLOT_ADDR_W = 2'd0;
  localparam logic [1:0] SLOT_REG    = 2'd1;
  localparam logic [1:0] SLOT_VALUE  = 2'd2;
  localparam logic [1:0] SLOT_ADDR_R = 2'd3;

  state_e     step_q, step_d, step_cur;
  logic [3:0] bit_cnt_q, bit_cnt_d, bit_cnt_cur;
  logic [7:0] shift_q, shift_d;
  logic [9:0] timer_q, timer_d, timer_cur, timer_inc;
  logic [7:0] held_reg_q, held_reg_d;
  logic [7:0] held_val_q, held_val_d;
  logic       is_read_q, is_read_d;
  logic [7:0] capt_q, capt_d;
  logic [1:0] slot_q, slot_d, slot_cur;
  logic [9:0] limit;
  logic       cmd_start, phase_end, done;
  logic       scl, sda, drv;
  logic [3:0] bit_cnt_inc;

  assign limit = (regs_i.half_period_ticks == '0) ? 10'd1 : regs_i.half_period_ticks;

  always_comb begin
    step_d      = step_q;
    bit_cnt_d   = bit_cnt_q;
    shift_d     = shift_q;
    held_reg_d  = held_reg_q;
    held_val_d  = held_val_q;
    is_read_d   = is_read_q;
    capt_d      = capt_q;
    slot_d      = slot_q;
    timer_d     = timer_q;
    done        = 1'b0;
    scl         = 1'b1;
    sda         = 1'b1;
    drv         = 1'b1;
    phase_end   = 1'b0;
    timer_inc   = '0;
    bit_cnt_inc = '0;

    // Drop any stray step code back to idle
    unique case (step_q)
      ST_IDLE, ST_START_A, ST_START_B, ST_WBIT_LO, ST_WBIT_HI, ST_WACK_LO,
      ST_WACK_HI, ST_RBIT_LO, ST_RBIT_HI, ST_NACK_LO, ST_NACK_HI,
      ST_STOP_A, ST_STOP_B, ST_STOP_C: step_cur = step_q;
      default: step_cur = ST_IDLE;
    endcase

    cmd_start   = (step_cur == ST_IDLE) &&
                  ((item_i.cmd == i2cra_pkg::CMD_WRITE) ||
                   (item_i.cmd == i2cra_pkg::CMD_READ));
    bit_cnt_cur = bit_cnt_q;
    slot_cur    = slot_q;
    timer_cur   = timer_q;
    if (cmd_start) begin
      held_reg_d  = item_i.reg_num;
      held_val_d  = item_i.write_data;
      is_read_d   = (item_i.cmd == i2cra_pkg::CMD_READ);
      slot_cur    = SLOT_ADDR_W;
      bit_cnt_cur = '0;
      timer_cur   = '0;
      step_cur    = ST_START_A;
    end
    step_d    = step_cur;
    bit_cnt_d = bit_cnt_cur;
    slot_d    = slot_cur;
    timer_d   = timer_cur;

    unique case (step_cur)
      ST_START_A: ;
      ST_START_B: sda = 1'b0;
      ST_WBIT_LO: begin scl = 1'b0; sda = shift_q[7]; end
      ST_WBIT_HI: sda = shift_q[7];
      ST_WACK_LO: begin scl = 1'b0; drv = 1'b0; end
      ST_WACK_HI: drv = 1'b0;
      ST_RBIT_LO: begin scl = 1'b0; drv = 1'b0; end
      ST_RBIT_HI: drv = 1'b0;
      ST_NACK_LO: scl = 1'b0;
      ST_NACK_HI: ;
      ST_STOP_A:  begin scl = 1'b0; sda = 1'b0; end
      ST_STOP_B:  sda = 1'b0;
      ST_STOP_C:  ;
      default:    drv = 1'b0;
    endcase

    if (step_cur != ST_IDLE) begin
      timer_inc = timer_cur + 10'd1;
      phase_end = (timer_inc >= limit) || (timer_inc == '0);
      timer_d   = phase_end ? '0 : timer_inc;
    end

    bit_cnt_inc = bit_cnt_cur + 4'd1;
    if (phase_end) begin
      unique case (step_cur)
        ST_START_A: step_d = ST_START_B;
        ST_START_B: begin
          shift_d   = {regs_i.device_address, slot_cur == SLOT_ADDR_R};
          bit_cnt_d = '0;
          step_d    = ST_WBIT_LO;
        end
        ST_WBIT_LO: step_d = ST_WBIT_HI;
        ST_WBIT_HI: begin
          shift_d   = {shift_q[6:0], 1'b0};
          bit_cnt_d = bit_cnt_inc;
          step_d    = (bit_cnt_inc >= 4'd8) ? ST_WACK_LO : ST_WBIT_LO;
        end
        ST_WACK_LO: step_d = ST_WACK_HI;
        ST_WACK_HI: begin
          bit_cnt_d = '0;
          if (slot_cur == SLOT_ADDR_W) begin
            slot_d  = SLOT_REG;
            shift_d = held_reg_q;
            step_d  = ST_WBIT_LO;
          end else if (slot_cur == SLOT_REG && !is_read_q) begin
            slot_d  = SLOT_VALUE;
            shift_d = held_val_q;
            step_d  = ST_WBIT_LO;
          end else if (slot_cur == SLOT_ADDR_R) begin
            shift_d = '0;
            step_d  = ST_RBIT_LO;
          end else begin
            step_d  = ST_STOP_A;
          end
        end
        ST_RBIT_LO: step_d = ST_RBIT_HI;
        ST_RBIT_HI: begin
          shift_d   = {shift_q[6:0], item_i.sda_in};
          bit_cnt_d = bit_cnt_inc;
          if (bit_cnt_inc >= 4'd8) begin
            capt_d = {shift_q[6:0], item_i.sda_in};
            step_d = ST_NACK_LO;
          end else begin
            step_d = ST_RBIT_LO;
          end
        end
        ST_NACK_LO: step_d = ST_NACK_HI;
        ST_NACK_HI: step_d = ST_STOP_A;
        ST_STOP_A:  step_d = ST_STOP_B;
        ST_STOP_B:  step_d = ST_STOP_C;
        ST_STOP_C: begin
          // After the stop, start again for the read half, otherwise finish
          if (is_read_q && slot_cur == SLOT_REG) begin
            slot_d = SLOT_ADDR_R;
            step_d = ST_START_A;
          end else begin
            step_d = ST_IDLE;
            done   = 1'b1;
          end
        end
        default: step_d = ST_IDLE;
      endcase
    end
  end

  always_comb begin
    res_o.scl       = scl;
    res_o.sda_out   = drv ? sda : 1'b1;
    res_o.sda_drive = drv;
    res_o.busy_res  = (step_cur != ST_IDLE);
    res_o.done_res  = done;
    res_o.read_data = capt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q     <= ST_IDLE;
      bit_cnt_q  <= '0;
      shift_q    <= '0;
      timer_q    <= '0;
      held_reg_q <= '0;
      held_val_q <= '0;
      is_read_q  <= 1'b0;
      capt_q     <= '0;
      slot_q     <= SLOT_ADDR_W;
    end else if (step_en_i) begin
      step_q     <= step_d;
      bit_cnt_q  <= bit_cnt_d;
      shift_q    <= shift_d;
      timer_q    <= timer_d;
      held_reg_q <= held_reg_d;
      held_val_q <= held_val_d;
      is_read_q  <= is_read_d;
      capt_q     <= capt_d;
      slot_q     <= slot_d;
    end
  end

  a_onehot_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(step_q))
    else $error("sequencer step lost its one-hot code");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bit_cnt_q <= 4'd8)
    else $error("bit counter ran past a byte");

  a_timer_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_en_i && !cmd_start |=> timer_q < limit || $past(step_q) == ST_IDLE)
    else $error("half period timer ran past its limit");

endmodule

// ===== hw/rtl/i2c_master_register_access.sv =====
// I2C register access master: each accepted input item is one timing tick, and each
// tick yields exactly one result with the SCL/SDA levels for that tick, so the block
// takes one item per clock cycle while results drain; each result appears in the cycle
// after its item. A single-pass phase sequencer that updates on every transfer feeds one
// output register; the input is taken whenever that register is empty or being drained.
// A write sends start, address+W, register, value, stop; a read sends start,
// address+W, register, stop, then start, address+R, eight sampled bits, NACK, stop.
// Each phase lasts half_period_ticks ticks (zero acts as one). Commands arriving while
// busy are ignored. Configuration is taken at any cycle; write it only while idle.
// Depends on i2cra_pkg, i2cra_stream_if and i2cra_seq.
module i2c_master_register_access (
  input  logic            clk_i,
  input  logic            rst_ni,
  i2cra_stream_if.sink    in_i,
  i2cra_stream_if.source  res_o,
  i2cra_stream_if.sink    cfg_i
);

  i2cra_pkg::cfg_regs_t regs_q;
  i2cra_pkg::res_t      res_d, res_q;
  i2cra_pkg::in_t       item;
  i2cra_pkg::cfg_wr_t   cfg_wr;
  logic                 out_valid_q;
  logic                 in_xfer;

  assign item       = in_i.payload;
  assign cfg_wr     = cfg_i.payload;
  assign cfg_i.ready = 1'b1;

  // Advance whenever the result register is free or drains this cycle
  assign in_i.ready = !out_valid_q || res_o.ready;
  assign in_xfer    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q.device_address    <= i2cra_pkg::DEV_ADDR_RESET;
      regs_q.half_period_ticks <= i2cra_pkg::HALF_PERIOD_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_wr.index)
        i2cra_pkg::CFG_DEVICE_ADDRESS:    regs_q.device_address    <= cfg_wr.data[6:0];
        i2cra_pkg::CFG_HALF_PERIOD_TICKS: regs_q.half_period_ticks <= cfg_wr.data;
        default: ;
      endcase
    end
  end

  i2cra_seq u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (in_xfer),
    .item_i    (item),
    .regs_i    (regs_q),
    .res_o     (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid   = out_valid_q;
  assign res_o.payload = res_q;

  a_xfer_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> out_valid_q)
    else $error("transfer did not produce a result");

  a_done_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.done_res |-> res_q.busy_res)
    else $error("done flagged outside a transaction");

  a_released_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !res_q.sda_drive |-> res_q.sda_out)
    else $error("released SDA reported low");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_i.ready)
    else $error("input stalled with an empty result register");

endmodule
